[rtl/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checker assertion failed");

// checked at every edge, reset included
`define CHK_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("checker assertion failed (no reset gate)");

`endif

[rtl/u8san_pkg.sv]
// types, constants and lead-byte decode for the utf-8 sanitizer
// no dependencies
package u8san_pkg;

    typedef logic [7:0] t_byte;

    localparam int unsigned MAX_WORDS = 4;
    localparam int unsigned HOLD_DEPTH = 3;

    localparam t_byte SPACE_BYTE = 8'h20;
    localparam t_byte MASK_ONE   = 8'h80;
    localparam t_byte MASK_TWO   = 8'hE0;
    localparam t_byte LEAD_TWO   = 8'hC0;
    localparam t_byte MASK_THREE = 8'hF0;
    localparam t_byte LEAD_THREE = 8'hE0;
    localparam t_byte MASK_FOUR  = 8'hF8;
    localparam t_byte LEAD_FOUR  = 8'hF0;
    localparam t_byte MASK_CONT  = 8'hC0;
    localparam t_byte CONT_BITS  = 8'h80;

    // words produced by one accepted byte, drained one per cycle while i_out_ready is high
    typedef struct packed {
        t_byte [MAX_WORDS-1:0] words;
        logic [1:0]            cnt_m1;
        logic                  last;
    } t_bundle;

    // sequence length from the lead byte, 0 for a bad lead
    function automatic logic [2:0] lead_length(input t_byte b);
        logic [2:0] len;
        if ((b & MASK_ONE) == 8'h00) begin
            len = 3'd1;
        end else if ((b & MASK_TWO) == LEAD_TWO) begin
            len = 3'd2;
        end else if ((b & MASK_THREE) == LEAD_THREE) begin
            len = 3'd3;
        end else if ((b & MASK_FOUR) == LEAD_FOUR) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

[rtl/utf8_sanitizer_top.sv]
// utf-8 framing sanitizer, top level
// depends on u8san_pkg
//
// Takes one byte per input word and returns the sanitized stream one byte per
// output word. A byte is decoded in the cycle it is accepted against the held
// sequence state, and the zero to four words it causes are written into a
// result register; its first word is offered on the next cycle if no earlier
// result waits. The output drains one word per cycle while i_out_ready is
// high, and bytes that cause at most one word flow at one per cycle unless the
// output stalls. A second result register lets the input keep accepting while
// a result still waits on the output. Only framing is checked (lead class and
// continuation pattern); bad leads and broken or unfinished sequences become
// 0x20 bytes, one per affected byte, and the breaking byte is decoded again
// as a new start. o_run_last marks the last word caused by an input byte,
// o_string_end the last word of a string.
module utf8_sanitizer_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  u8san_pkg::t_byte i_in_byte,
    input  logic            i_in_last,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output u8san_pkg::t_byte o_out_byte,
    output logic            o_run_last,
    output logic            o_string_end
);
    import u8san_pkg::*;

    // held sequence state
    t_byte      r_pend [HOLD_DEPTH];
    t_byte      n_pend [HOLD_DEPTH];
    logic [1:0] r_pcnt, n_pcnt;
    logic [2:0] r_elen, n_elen;

    // result registers
    t_bundle    r_cur, n_cur, r_nxt, n_nxt;
    logic       r_cur_v, n_cur_v, r_nxt_v, n_nxt_v;
    logic [1:0] r_idx, n_idx;

    t_bundle    new_bundle;
    logic [2:0] word_cnt;
    logic       in_fire, out_fire, push, cur_done;
    logic       is_cont, handled;
    logic [2:0] llen;

    assign o_in_ready = !r_nxt_v;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_cur_v && i_out_ready;
    assign cur_done   = (r_idx == r_cur.cnt_m1);

    assign o_out_valid  = r_cur_v;
    assign o_out_byte   = r_cur.words[r_idx];
    assign o_run_last   = cur_done;
    assign o_string_end = cur_done && r_cur.last;

    // decode of the incoming byte
    always_comb begin
        is_cont  = ((i_in_byte & MASK_CONT) == CONT_BITS);
        llen     = lead_length(i_in_byte);
        handled  = 1'b0;
        word_cnt = 3'd0;
        n_pcnt   = r_pcnt;
        n_elen   = r_elen;
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            n_pend[i] = r_pend[i];
        end
        new_bundle.words  = {MAX_WORDS{SPACE_BYTE}};
        new_bundle.last   = i_in_last;

        if (r_pcnt != 2'd0) begin
            if (is_cont) begin
                handled = 1'b1;
                if ({1'b0, r_pcnt} + 3'd1 >= r_elen) begin
                    // sequence complete, release it unchanged
                    for (int i = 0; i < HOLD_DEPTH; i++) begin
                        if (i < int'(r_pcnt)) begin
                            new_bundle.words[i] = r_pend[i];
                        end
                    end
                    new_bundle.words[r_pcnt] = i_in_byte;
                    word_cnt = {1'b0, r_pcnt} + 3'd1;
                    n_pcnt   = 2'd0;
                    n_elen   = 3'd0;
                end else if (i_in_last) begin
                    // string ends mid-sequence
                    word_cnt = {1'b0, r_pcnt} + 3'd1;
                    n_pcnt   = 2'd0;
                    n_elen   = 3'd0;
                end else begin
                    n_pend[r_pcnt] = i_in_byte;
                    n_pcnt         = r_pcnt + 2'd1;
                end
            end else begin
                // broken sequence, one space per held byte
                word_cnt = {1'b0, r_pcnt};
                n_pcnt   = 2'd0;
                n_elen   = 3'd0;
            end
        end

        if (!handled) begin
            if (llen == 3'd1) begin
                new_bundle.words[word_cnt[1:0]] = i_in_byte;
                word_cnt = word_cnt + 3'd1;
            end else if (llen == 3'd0 || i_in_last) begin
                word_cnt = word_cnt + 3'd1;
            end else begin
                n_pend[0] = i_in_byte;
                n_pcnt    = 2'd1;
                n_elen    = llen;
            end
        end

        new_bundle.cnt_m1 = 2'(word_cnt - 3'd1);
        push = in_fire && (word_cnt != 3'd0);
    end

    // result register management
    always_comb begin
        n_cur   = r_cur;
        n_nxt   = r_nxt;
        n_cur_v = r_cur_v;
        n_nxt_v = r_nxt_v;
        n_idx   = r_idx;
        if (out_fire) begin
            if (cur_done) begin
                n_idx   = 2'd0;
                n_cur_v = 1'b0;
                if (r_nxt_v) begin
                    n_cur   = r_nxt;
                    n_cur_v = 1'b1;
                    n_nxt_v = 1'b0;
                end
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (push) begin
            if (!n_cur_v) begin
                n_cur   = new_bundle;
                n_cur_v = 1'b1;
            end else begin
                n_nxt   = new_bundle;
                n_nxt_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt  <= 2'd0;
            r_elen  <= 3'd0;
            r_cur_v <= 1'b0;
            r_nxt_v <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (in_fire) begin
                r_pcnt <= n_pcnt;
                r_elen <= n_elen;
            end
            r_cur_v <= n_cur_v;
            r_nxt_v <= n_nxt_v;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                r_pend[i] <= n_pend[i];
            end
        end
        r_cur <= n_cur;
        r_nxt <= n_nxt;
    end

endmodule

[rtl/u8san_checker.sv]
// port-level checker for the utf-8 sanitizer, bound to the top level
// depends on assert_macros.svh, u8san_pkg and utf8_sanitizer_top
`include "assert_macros.svh"

module u8san_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input u8san_pkg::t_byte o_out_byte,
    input logic             o_run_last,
    input logic             o_string_end
);
    import u8san_pkg::*;

    // a stalled word holds
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `CHK_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_byte))
    `CHK_ASSERT(a_end_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_string_end))

    // end of string only on the last word of a run
    `CHK_ASSERT(a_end_in_run, i_clk, i_rst_n, o_out_valid && o_string_end |-> o_run_last)

    // reset empties the result registers
    `CHK_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)

endmodule

bind utf8_sanitizer_top u8san_checker u_u8san_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_run_last   (o_run_last),
    .o_string_end (o_string_end)
);

[verif/utf8_sanitizer_top_test.sv]
// self-checking testbench for utf8_sanitizer_top: directed and random byte strings
// depends on u8san_pkg and utf8_sanitizer_top; a scoreboard class predicts every output word
`timescale 1ns / 100ps

module utf8_sanitizer_top_test;

    import u8san_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_PRINTED = 100;

    typedef struct {
        t_byte data;
        logic  run_last;
        logic  string_end;
    } t_out_word;

    class u8san_scoreboard;
        t_out_word   expected_words[$];
        t_byte       held[HOLD_DEPTH];
        int unsigned held_cnt;
        int unsigned seq_len;
        int unsigned errors;
        int unsigned bytes_taken;
        int unsigned words_seen;

        function new();
            held_cnt = 0;
            seq_len = 0;
            errors = 0;
            bytes_taken = 0;
            words_seen = 0;
            foreach (held[k]) held[k] = 8'h00;
        endfunction

        function int unsigned class_len(t_byte b);
            int unsigned len;
            if ((b & MASK_ONE) == 8'h00) begin
                len = 1;
            end else if ((b & MASK_TWO) == LEAD_TWO) begin
                len = 2;
            end else if ((b & MASK_THREE) == LEAD_THREE) begin
                len = 3;
            end else if ((b & MASK_FOUR) == LEAD_FOUR) begin
                len = 4;
            end else begin
                len = 0;
            end
            return len;
        endfunction

        function void push_word(t_byte b);
            t_out_word w;
            w.data = b;
            w.run_last = 1'b0;
            w.string_end = 1'b0;
            expected_words = {expected_words, w};
        endfunction

        // predict the words caused by one accepted input byte
        function void note_byte(t_byte b, logic last);
            int unsigned first_n;
            int unsigned len;
            bit          taken;
            first_n = expected_words.size();
            taken = 0;
            bytes_taken++;
            if (held_cnt != 0) begin
                if ((b & MASK_CONT) == CONT_BITS) begin
                    taken = 1;
                    if (held_cnt + 1 >= seq_len) begin
                        for (int i = 0; i < held_cnt; i++) push_word(held[i]);
                        push_word(b);
                        held_cnt = 0;
                        seq_len = 0;
                    end else if (last) begin
                        for (int i = 0; i <= held_cnt; i++) push_word(SPACE_BYTE);
                        held_cnt = 0;
                        seq_len = 0;
                    end else begin
                        held[held_cnt] = b;
                        held_cnt++;
                    end
                end else begin
                    // broken sequence: blank what was held, then rescan this byte
                    for (int i = 0; i < held_cnt; i++) push_word(SPACE_BYTE);
                    held_cnt = 0;
                    seq_len = 0;
                end
            end
            if (!taken) begin
                len = class_len(b);
                if (len == 1) begin
                    push_word(b);
                end else if (len == 0 || last) begin
                    push_word(SPACE_BYTE);
                end else begin
                    held[0] = b;
                    held_cnt = 1;
                    seq_len = len;
                end
            end
            if (expected_words.size() > first_n) begin
                expected_words[expected_words.size() - 1].run_last = 1'b1;
                expected_words[expected_words.size() - 1].string_end = last;
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(t_byte b, logic rl, logic se);
            t_out_word w;
            words_seen++;
            if (expected_words.size() == 0) begin
                report($sformatf("word %02h run_last %b string_end %b with none expected",
                                 b, rl, se));
            end else begin
                w = expected_words.pop_front();
                if (b !== w.data || rl !== w.run_last || se !== w.string_end) begin
                    report($sformatf("word %0d got %02h/%b/%b expected %02h/%b/%b",
                                     words_seen, b, rl, se,
                                     w.data, w.run_last, w.string_end));
                end
            end
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    t_byte i_in_byte = 8'h00;
    logic  i_in_last = 1'b0;
    logic  i_out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_byte o_out_byte;
    logic  o_run_last;
    logic  o_string_end;

    u8san_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_on = 1'b0;
    int unsigned cycle_cnt = 0;
    t_byte       str_q[$];

    utf8_sanitizer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("utf8_sanitizer_top regression: fail");
            $finish;
        end
    end

    // output side: check each accepted word, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word(o_out_byte, o_run_last, o_string_end);
        end
        if (hold_on) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input t_byte b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, last);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
    endtask

    // lead with random payload bits, followed by n_cont continuation bytes
    function automatic void add_seq(int unsigned len, int unsigned n_cont);
        t_byte r;
        r = t_byte'($urandom);
        case (len)
            1: str_q = {str_q, {1'b0, r[6:0]}};
            2: str_q = {str_q, {3'b110, r[4:0]}};
            3: str_q = {str_q, {4'b1110, r[3:0]}};
            default: str_q = {str_q, {5'b11110, r[2:0]}};
        endcase
        for (int i = 0; i < n_cont; i++) begin
            r = t_byte'($urandom);
            str_q = {str_q, {2'b10, r[5:0]}};
        end
    endfunction

    function automatic void build_string();
        int unsigned n_chars;
        int unsigned kind;
        int unsigned len;
        t_byte       r;
        str_q.delete();
        n_chars = $urandom_range(1, 8);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(99);
            len = $urandom_range(1, 4);
            if (kind < 72) begin
                add_seq(len, len - 1);
            end else if (kind < 86) begin
                r = t_byte'($urandom);
                str_q = {str_q, r};
            end else begin
                // truncated sequence, broken by what follows unless that is a continuation byte, or by the end
                len = $urandom_range(2, 4);
                add_seq(len, $urandom_range(0, len - 2));
            end
        end
    endfunction

    task automatic send_random(int unsigned n_items);
        int unsigned sent;
        sent = 0;
        while (sent < n_items) begin
            build_string();
            foreach (str_q[k]) send_word(str_q[k], k == str_q.size() - 1);
            sent += str_q.size();
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ascii extremes, each sequence length, bad leads, breaks, cut-off ends
        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h41, 1'b1);
        send_word(8'hC3, 1'b0);
        send_word(8'hA9, 1'b1);
        send_word(8'hE2, 1'b0);
        send_word(8'h82, 1'b0);
        send_word(8'hAC, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'h9F, 1'b0);
        send_word(8'h98, 1'b0);
        send_word(8'h80, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hF8, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hE2, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'hF4, 1'b0);
        send_word(8'h8F, 1'b0);
        send_word(8'hDF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hF7, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b1);
        send_word(8'hEF, 1'b1);
        send_word(8'hC2, 1'b0);
        send_word(8'hE0, 1'b1);
        wait_drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(100);
        wait_drain();

        send_idle_pct = 82;
        recv_stall_pct = 0;
        send_random(100);
        wait_drain();

        send_idle_pct = 0;
        recv_stall_pct = 82;
        send_random(100);
        wait_drain();

        send_idle_pct = 30;
        recv_stall_pct = 30;
        send_random(100);
        wait_drain();

        // output held off while the input keeps offering words
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join_none
        send_random(30);
        wait_drain();
        repeat (20) @(posedge i_clk);

        $display("sent %0d bytes, checked %0d output words", sb.bytes_taken, sb.words_seen);
        $display("covered free flow, input gaps, output stalls, both, and a long output hold");
        if (sb.errors == 0) begin
            $display("utf8_sanitizer_top regression: pass");
        end else begin
            $display("utf8_sanitizer_top regression: fail");
        end
        $finish;
    end

endmodule
